[rtl/a85_pkg.sv]
// ----------------------------------------------------------------------------
// a85_pkg: shared types and constants of the base-85 stream encoder
// Holds the job record passed from the byte packer to the converter, the
// digit record passed from the converter to the serializer, and the
// arithmetic constants of the radix conversion.
// ----------------------------------------------------------------------------
package a85_pkg;

  localparam int unsigned NUM_DIGITS = 5;
  localparam int unsigned DIGIT_W    = 7;

  localparam logic [7:0]  CHAR_BIAS  = 8'd33;
  localparam logic [7:0]  NEWLINE    = 8'd10;
  localparam logic [7:0]  RADIX      = 8'd85;

  // Reciprocal of 85 scaled by 2^38, rounded up; exact quotient for any 32-bit word
  localparam logic [31:0] RECIP_85   = 32'hC0C0_C0C1;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam int unsigned QUOT_W     = 26;

  // Serializer position of the newline character
  localparam logic [2:0]  NL_POS     = 3'd5;
  localparam logic [2:0]  LAST_DIGIT = 3'd4;

  // What a job asks the back end to produce
  typedef enum logic [1:0] {
    KIND_WORD  = 2'd0,  // five digits, last on the fifth
    KIND_FLUSH = 2'd1,  // five digits, then newline
    KIND_NL    = 2'd2   // newline only
  } a85_kind_t;

  typedef struct packed {
    a85_kind_t   kind;
    logic [31:0] word;
  } a85_job_t;

  typedef struct packed {
    a85_kind_t                               kind;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]      digits;  // index 0 is most significant
  } a85_digits_t;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_MUL,
    CV_DIV,
    CV_DONE
  } a85_cv_state_t;

endpackage

[rtl/a85_front.sv]
// ----------------------------------------------------------------------------
// a85_front: byte packer
// Packs data bytes big-endian into a 32-bit word and turns each full word or
// end-of-stream marker into a job for the back end.
// ----------------------------------------------------------------------------
module a85_front import a85_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] data_byte
  input  logic       in_tuser,    // [0] func: 0 data byte, 1 end of stream
  output logic       job_valid,
  input  logic       job_ready,
  output a85_job_t   job
);

  logic [31:0] word_r, word_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        accept;
  logic [31:0] padded;

  // Stall input whenever the job queue cannot take a word
  assign in_tready = job_ready;
  assign accept    = in_tvalid && in_tready;

  // Pad pending bytes with zero bytes at the low end
  always_comb begin
    case (cnt_r)
      2'd1:    padded = {word_r[7:0], 24'd0};
      2'd2:    padded = {word_r[15:0], 16'd0};
      2'd3:    padded = {word_r[23:0], 8'd0};
      default: padded = 32'd0;
    endcase
  end

  // Classify the word and build the job
  always_comb begin
    word_nxt  = word_r;
    cnt_nxt   = cnt_r;
    job_valid = 1'b0;
    job.kind  = KIND_WORD;
    job.word  = {word_r[23:0], in_tdata};
    if (accept) begin
      if (!in_tuser) begin
        word_nxt = {word_r[23:0], in_tdata};
        cnt_nxt  = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          job_valid = 1'b1;
          word_nxt  = 32'd0;
        end
      end else begin
        job_valid = 1'b1;
        word_nxt  = 32'd0;
        cnt_nxt   = 2'd0;
        if (cnt_r == 2'd0) begin
          job.kind = KIND_NL;
          job.word = 32'd0;
        end else begin
          job.kind = KIND_FLUSH;
          job.word = padded;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= 32'd0;
      cnt_r  <= 2'd0;
    end else begin
      word_r <= word_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

[rtl/a85_queue.sv]
// ----------------------------------------------------------------------------
// a85_queue: job queue
// Short first-in first-out queue of jobs between the byte packer and the
// radix converter, so either side can stall on its own.
// ----------------------------------------------------------------------------
module a85_queue import a85_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  a85_job_t push_job,
  output logic     pop_valid,
  input  logic     pop_ready,
  output a85_job_t pop_job
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  a85_job_t          slots_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push, do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_job    = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Write the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[rtl/a85_conv.sv]
// ----------------------------------------------------------------------------
// a85_conv: radix-85 converter
// Splits a 32-bit word into five base-85 digits by repeated division by 85,
// each a reciprocal multiply state, then a remainder subtract state.
// ----------------------------------------------------------------------------
module a85_conv import a85_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  output logic        job_ready,
  input  a85_job_t    job,
  output logic        dig_valid,
  input  logic        dig_ready,
  output a85_digits_t dig
);

  a85_cv_state_t                       state_r, state_nxt;
  logic [31:0]                         word_r;
  logic [QUOT_W-1:0]                   quot_r;
  logic [2:0]                          pos_r;
  a85_kind_t                           kind_r;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  digits_r;
  logic [63:0]                         product;
  logic [31:0]                         quot_times;
  logic [31:0]                         remainder;
  logic                                hand_off;
  logic                                take;

  assign product    = {32'd0, word_r} * {32'd0, RECIP_85};
  assign quot_times = {6'd0, quot_r} * {24'd0, RADIX};
  assign remainder  = word_r - quot_times;

  assign dig_valid  = (state_r == CV_DONE);
  assign hand_off   = dig_valid && dig_ready;
  assign job_ready  = (state_r == CV_IDLE) || hand_off;
  assign take       = job_valid && job_ready;
  assign dig.kind   = kind_r;
  assign dig.digits = digits_r;

  // Sequence the divisions
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CV_IDLE: begin
        if (take) begin
          state_nxt = (job.kind == KIND_NL) ? CV_DONE : CV_MUL;
        end
      end
      CV_MUL: begin
        state_nxt = CV_DIV;
      end
      CV_DIV: begin
        state_nxt = (pos_r == 3'd1) ? CV_DONE : CV_MUL;
      end
      CV_DONE: begin
        if (take) begin
          state_nxt = (job.kind == KIND_NL) ? CV_DONE : CV_MUL;
        end else if (hand_off) begin
          state_nxt = CV_IDLE;
        end
      end
      default: state_nxt = CV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Load a job, then peel off the least significant digit each division
  always_ff @(posedge clk) begin
    if (take) begin
      word_r <= job.word;
      kind_r <= job.kind;
      pos_r  <= LAST_DIGIT;
    end else if (state_r == CV_MUL) begin
      quot_r <= product[RECIP_SHIFT +: QUOT_W];
    end else if (state_r == CV_DIV) begin
      word_r <= {6'd0, quot_r};
      pos_r  <= pos_r - 3'd1;
      // Last division: the quotient is the most significant digit
      if (pos_r == 3'd1) begin
        digits_r[1:0] <= {remainder[DIGIT_W-1:0], quot_r[DIGIT_W-1:0]};
      end else begin
        digits_r[pos_r] <= remainder[DIGIT_W-1:0];
      end
    end
  end

endmodule

[rtl/a85_ser.sv]
// ----------------------------------------------------------------------------
// a85_ser: character serializer
// Holds one converted word and drives its characters, most significant
// digit first, followed by a newline on a flush; a newline-only job drives the newline alone.
// ----------------------------------------------------------------------------
module a85_ser import a85_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        dig_valid,
  output logic        dig_ready,
  input  a85_digits_t dig,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  output logic        out_tlast
);

  logic                                busy_r;
  logic [2:0]                          pos_r;
  a85_kind_t                           kind_r;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  digits_r;
  logic [DIGIT_W-1:0]                  cur_digit;
  logic                                fire;
  logic                                load;

  assign out_tvalid = busy_r;
  assign fire       = out_tvalid && out_tready;
  assign dig_ready  = !busy_r || (fire && out_tlast);
  assign load       = dig_valid && dig_ready;

  // Select the current character
  always_comb begin
    case (pos_r)
      3'd0:    cur_digit = digits_r[0];
      3'd1:    cur_digit = digits_r[1];
      3'd2:    cur_digit = digits_r[2];
      3'd3:    cur_digit = digits_r[3];
      3'd4:    cur_digit = digits_r[4];
      default: cur_digit = '0;
    endcase
  end

  assign out_tdata = (pos_r == NL_POS) ? NEWLINE : ({1'b0, cur_digit} + CHAR_BIAS);
  assign out_tlast = (pos_r == NL_POS) || ((pos_r == LAST_DIGIT) && (kind_r == KIND_WORD));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (load) begin
      busy_r <= 1'b1;
    end else if (fire && out_tlast) begin
      busy_r <= 1'b0;
    end
  end

  // Load a word or advance one character
  always_ff @(posedge clk) begin
    if (load) begin
      digits_r <= dig.digits;
      kind_r   <= dig.kind;
      pos_r    <= (dig.kind == KIND_NL) ? NL_POS : 3'd0;
    end else if (fire) begin
      pos_r <= pos_r + 3'd1;
    end
  end

endmodule

[rtl/ascii85_stream_encoder.sv]
// ----------------------------------------------------------------------------
// ascii85_stream_encoder: base-85 byte stream encoder
// Input stream: in_tdata carries a byte, in_tuser high marks end of stream
// (the byte is then ignored). Output stream: one character per word on
// out_tdata, out_tlast high on the final character caused by an input word.
// Every fourth data byte yields five characters (digit + 33, most significant
// first). End of stream with bytes pending pads them with zeros, yields five
// characters and a newline; with nothing pending it yields a newline alone.
// A completing byte passes the job queue, the converter's multiply and
// subtract states, the hand-off and the serializer's output register before
// its first character. Throughput is set by the shared divide-by-85 unit
// (multiply, then subtract, four times), busy until each word is handed off.
// Bytes that complete no word are taken every cycle while the queue has room.
// Reset (rst_n low, synchronous) drops pending bytes, queued jobs and any
// character in flight. When out_tready stays low the current character holds,
// the converter finishes one more word, the queue fills and in_tready falls.
// ----------------------------------------------------------------------------
module ascii85_stream_encoder import a85_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] data_byte
  input  logic       in_tuser,    // [0] func
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_char
  output logic       out_tlast
);

  logic        fj_valid, fj_ready;
  a85_job_t    fj;
  logic        qj_valid, qj_ready;
  a85_job_t    qj;
  logic        cd_valid, cd_ready;
  a85_digits_t cd;

  a85_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .job_valid (fj_valid),
    .job_ready (fj_ready),
    .job       (fj)
  );

  a85_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fj_valid),
    .push_ready (fj_ready),
    .push_job   (fj),
    .pop_valid  (qj_valid),
    .pop_ready  (qj_ready),
    .pop_job    (qj)
  );

  a85_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (qj_valid),
    .job_ready (qj_ready),
    .job       (qj),
    .dig_valid (cd_valid),
    .dig_ready (cd_ready),
    .dig       (cd)
  );

  a85_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .dig_valid  (cd_valid),
    .dig_ready  (cd_ready),
    .dig        (cd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stream test of the base-85 byte encoder
// Feeds data bytes and end-of-stream words through the input stream, while
// both stream sides idle and stall at random. A local model packs each
// accepted byte, turns finished or flushed words into characters and queues
// them. Every character that leaves the block is checked, in order, against
// the oldest queued one.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic        FUNC_BYTE  = 1'b0;
  localparam logic        FUNC_FLUSH = 1'b1;
  localparam int unsigned BASE       = 85;
  localparam logic [7:0]  DIGIT_OFS  = 8'd33;
  localparam logic [7:0]  LF_CHAR    = 8'd10;
  localparam int          STALL_MAX  = 2000;
  localparam int          RANDOM_ITEMS = 144;

  typedef struct {
    logic       func;
    logic [7:0] data;
  } byte_word_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'd0;
  logic       in_tuser = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  byte_word_t pending_words[$];
  enc_char_t  expected_chars[$];

  // Encoder model state
  logic [31:0] acc_word = 32'd0;
  int          acc_count = 0;

  logic in_taken = 1'b0;
  int   words_in = 0;
  int   fail_count = 0;
  int   quiet_cycles = 0;
  logic calm;

  ascii85_stream_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // No idling on either side over a stretch in the middle of the run
  assign calm = (words_in >= 90) && (words_in < 140);

  // Queue the five digits of a word, most significant first
  function automatic void queue_digits(input logic [31:0] w, input logic last_on_fifth);
    logic [7:0] digs[5];
    logic [31:0] rem;
    enc_char_t c;
    rem = w;
    for (int i = 4; i >= 0; i--) begin
      digs[i] = 8'(rem % BASE) + DIGIT_OFS;
      rem = rem / BASE;
    end
    for (int i = 0; i < 5; i++) begin
      c.ch = digs[i];
      c.last = (i == 4) ? last_on_fifth : 1'b0;
      expected_chars.push_back(c);
    end
  endfunction

  // Advance the model by one accepted word and queue the characters it causes
  function automatic void encode_word(input logic func, input logic [7:0] b);
    enc_char_t lf;
    lf.ch = LF_CHAR;
    lf.last = 1'b1;
    if (func == FUNC_BYTE) begin
      acc_word = {acc_word[23:0], b};
      acc_count++;
      if (acc_count == 4) begin
        queue_digits(acc_word, 1'b1);
        acc_word = 32'd0;
        acc_count = 0;
      end
    end else begin
      // Pad pending bytes with zeros; nothing pending gives a newline alone
      if (acc_count != 0) begin
        queue_digits(acc_word << (8 * (4 - acc_count)), 1'b0);
      end
      expected_chars.push_back(lf);
      acc_word = 32'd0;
      acc_count = 0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH %s: got 0x%02h, want 0x%02h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic void add_word(input logic func, input logic [7:0] b);
    byte_word_t w;
    w.func = func;
    w.data = b;
    pending_words.push_back(w);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Drive the input stream
  always @(negedge clk) begin : drive_in
    byte_word_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
        w = pending_words.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= w.data;
        in_tuser <= w.func;
      end else begin
        in_tvalid <= 1'b0;
        in_tdata <= 8'($urandom);
        in_tuser <= 1'($urandom);
      end
    end
  end

  // Stall the output stream
  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 33);
  end

  // Sample both streams, predict and check
  always @(posedge clk) begin : watch
    enc_char_t want;
    in_taken <= in_tvalid && in_tready && rst_n;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        encode_word(in_tuser, in_tdata);
        words_in <= words_in + 1;
      end
      if (out_tvalid && out_tready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("unexpected char", out_tdata, 8'h00);
        end else begin
          want = expected_chars.pop_front();
          if (out_tdata !== want.ch)
            report_mismatch("char", out_tdata, want.ch);
          if (out_tlast !== want.last)
            report_mismatch("tlast", {7'd0, out_tlast}, {7'd0, want.last});
        end
      end
    end
  end

  // Watchdog on cycles with no word accepted on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int n;
    // Directed: all-zero word (no shortcut), all-ones word, empty flush
    repeat (4) add_word(FUNC_BYTE, 8'h00);
    repeat (4) add_word(FUNC_BYTE, 8'hFF);
    add_word(FUNC_FLUSH, 8'h00);
    // Flush with one, two and three bytes pending; flush ignores its byte
    add_word(FUNC_BYTE, 8'hA5);
    add_word(FUNC_FLUSH, 8'h5A);
    add_word(FUNC_BYTE, 8'hFF);
    add_word(FUNC_BYTE, 8'h01);
    add_word(FUNC_FLUSH, 8'hFF);
    add_word(FUNC_BYTE, 8'h80);
    add_word(FUNC_BYTE, 8'h7F);
    add_word(FUNC_BYTE, 8'hFE);
    add_word(FUNC_FLUSH, 8'h33);
    add_word(FUNC_FLUSH, 8'hC3);
    add_word(FUNC_BYTE, 8'h80);
    add_word(FUNC_BYTE, 8'h00);
    add_word(FUNC_BYTE, 8'h00);
    add_word(FUNC_BYTE, 8'h01);

    // Random: mostly byte runs, some closed by a flush, some stray flushes
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if ($urandom_range(9) == 0) begin
        add_word(FUNC_FLUSH, 8'($urandom));
        n++;
      end else begin
        repeat ($urandom_range(1, 12)) begin
          add_word(FUNC_BYTE, pick_byte());
          n++;
        end
        if ($urandom_range(1) == 1) begin
          add_word(FUNC_FLUSH, 8'($urandom));
          n++;
        end
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_words.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
